// ----- design/bounded_priority_message_queue_core_macros.svh -----
// Assertion macros shared by the message queue RTL.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef BOUNDED_PRIORITY_MESSAGE_QUEUE_CORE_MACROS_SVH
`define BOUNDED_PRIORITY_MESSAGE_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define BPMQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define BPMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BPMQ_ASSERT_IMPL(label, ante, cons)
`define BPMQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/bpmq_pkg.sv -----
// Shared types and constants for the bounded priority message queue.
// No dependencies; used by bpmq_regs, bpmq_cell and the top level.
package bpmq_pkg;

  localparam int DEPTH_DEFAULT   = 64;
  localparam int MAX_LEN_DEFAULT = 8192;

  localparam int PRIO_W = 32;
  localparam int LEN_W  = 16;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 7;
  localparam int MLEN_W = 14;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 7'd10;
  localparam logic [MLEN_W-1:0] MAX_LEN_RESET  = 14'd8192;

  // register index, taken from the word address bit
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_MAX_LEN  = 1'b1;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADLEN = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_TOOBIG = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } op_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t item;
  } cell_cmd_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [MLEN_W-1:0] max_msg_len;
  } cfg_t;

endpackage

// ----- design/bounded_priority_message_queue_core.sv -----
// Top level of the bounded priority message queue: stream ports, command
// decode, result register and the chain of bpmq_cell slots.
// Depends on bpmq_pkg, bpmq_regs, bpmq_cell and the macros header.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: prio, length, payload; tuser: cmd
//  m_*       out  m_tvalid/m_tready  tdata: status, prio, length, payload, occ
//  apb       in   psel/penable/pready capacity @0x0, max_msg_len @0x4
//
// One word per cycle while s_tready is high: every slot compares against the
// new priority at once, so a send or receive needs no search; the result is
// registered and valid in the cycle after the input word. s_tready drops only
// while a result is held and m_tready is low. Reset clears the message count,
// the result valid flag and the registers; slot contents are not cleared.
`include "bounded_priority_message_queue_core_macros.svh"

module bounded_priority_message_queue_core #(
  parameter int DEPTH   = bpmq_pkg::DEPTH_DEFAULT,
  parameter int MAX_LEN = bpmq_pkg::MAX_LEN_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [79:0]                 s_tdata,  // priority_req, length, payload
  input  logic [0:0]                  s_tuser,  // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [87:0]                 m_tdata,  // status, out_priority,
                                                // out_length, out_payload,
                                                // occupancy
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpmq_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > bpmq_pkg::CAP_W) ? CNT_W : bpmq_pkg::CAP_W;

  bpmq_pkg::cfg_t      cfg;
  bpmq_pkg::cell_cmd_t cmd;
  bpmq_pkg::entry_t    cells   [DEPTH];
  logic [DEPTH-1:0]    ge;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             in_cmd;
  bpmq_pkg::entry_t in_item;
  bpmq_pkg::op_t    op_c;
  logic [2:0]       status_c;
  logic             deliver_c;
  logic [CW-1:0]    cap_lim;
  logic [bpmq_pkg::LEN_W-1:0] len_lim;
  logic             bad_len;
  logic             full;

  logic [2:0]                   status;
  logic [bpmq_pkg::PRIO_W-1:0]  out_priority;
  logic [bpmq_pkg::MLEN_W-1:0]  out_length;
  logic [bpmq_pkg::WORD_W-1:0]  out_payload;
  logic [bpmq_pkg::CAP_W-1:0]   occupancy;

  bpmq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign in_cmd          = s_tuser[0];
  assign in_item.prio    = s_tdata[31:0];
  assign in_item.len     = s_tdata[47:32];
  assign in_item.payload = s_tdata[79:48];

  // saturate the limits to what the hardware holds
  assign cap_lim = (CW'(cfg.capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg.capacity);
  assign len_lim = (bpmq_pkg::LEN_W'(cfg.max_msg_len) > bpmq_pkg::LEN_W'(MAX_LEN)) ?
                   bpmq_pkg::LEN_W'(MAX_LEN) : bpmq_pkg::LEN_W'(cfg.max_msg_len);
  assign bad_len = (in_item.len == '0) || (in_item.len > len_lim);
  assign full    = CW'(count) >= cap_lim;

  always_comb begin
    op_c       = bpmq_pkg::OP_HOLD;
    status_c   = bpmq_pkg::ST_OK;
    deliver_c  = 1'b0;
    count_next = count;
    if (in_cmd == bpmq_pkg::CMD_SEND) begin
      if (bad_len) begin
        status_c = bpmq_pkg::ST_BADLEN;
      end else if (full) begin
        status_c = bpmq_pkg::ST_FULL;
      end else begin
        op_c       = bpmq_pkg::OP_INSERT;
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_c = bpmq_pkg::ST_EMPTY;
      end else begin
        // drop the head even when it does not fit the buffer
        op_c       = bpmq_pkg::OP_REMOVE;
        count_next = count - 1'b1;
        if (cells[0].len > in_item.len) begin
          status_c = bpmq_pkg::ST_TOOBIG;
        end else begin
          deliver_c = 1'b1;
        end
      end
    end
  end

  assign cmd.op   = accept ? op_c : bpmq_pkg::OP_HOLD;
  assign cmd.item = in_item;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bpmq_pkg::entry_t left_e;
    bpmq_pkg::entry_t right_e;
    logic             left_g;

    if (i == 0) begin : g_first
      // the head has no left neighbor: it takes a new entry that outranks it
      assign left_e = cells[0];
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_g = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cells[i];
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    bpmq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .left_ge     (left_g),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cells[i]),
      .ge          (ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result word; payload fields need no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_c;
      out_priority <= deliver_c ? cells[0].prio : '0;
      out_length   <= deliver_c ? cells[0].len[bpmq_pkg::MLEN_W-1:0] : '0;
      out_payload  <= deliver_c ? cells[0].payload : '0;
      occupancy    <= bpmq_pkg::CAP_W'(count_next);
    end
  end

  assign m_tdata = {occupancy, out_payload, out_length, out_priority, status};

  `BPMQ_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `BPMQ_ASSERT_IMPL(a_insert_room, cmd.op == bpmq_pkg::OP_INSERT, !full && !bad_len)
  `BPMQ_ASSERT_IMPL(a_remove_held, cmd.op == bpmq_pkg::OP_REMOVE, count != '0)
  `BPMQ_ASSERT_NEXT(a_accept_result, accept, m_tvalid && (count == $past(count_next)))
  `BPMQ_ASSERT_IMPL(a_head_sorted, count >= CNT_W'(2), cells[0].prio >= cells[1].prio)

endmodule

// ----- design/bpmq_regs.sv -----
// APB-style configuration registers for the message queue.
// Depends on bpmq_pkg.
module bpmq_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bpmq_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output bpmq_pkg::cfg_t                     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity    <= bpmq_pkg::CAPACITY_RESET;
      cfg.max_msg_len <= bpmq_pkg::MAX_LEN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bpmq_pkg::REG_CAPACITY: cfg.capacity    <= pwdata[bpmq_pkg::CAP_W-1:0];
        bpmq_pkg::REG_MAX_LEN:  cfg.max_msg_len <= pwdata[bpmq_pkg::MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bpmq_pkg::REG_CAPACITY: prdata = 32'(cfg.capacity);
      bpmq_pkg::REG_MAX_LEN:  prdata = 32'(cfg.max_msg_len);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- design/bpmq_cell.sv -----
// One slot of the sorted shift chain: holds an entry, compares it with the
// broadcast priority and takes its own, the new, or a neighbor's entry.
// Depends on bpmq_pkg.
module bpmq_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  bpmq_pkg::cell_cmd_t   cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic                  left_ge,
  input  bpmq_pkg::entry_t      left_entry,
  input  bpmq_pkg::entry_t      right_entry,
  output bpmq_pkg::entry_t      entry,
  output logic                  ge
);

  logic             occupied;
  bpmq_pkg::entry_t entry_next;

  assign occupied = (CNT_W'(INDEX) < count);
  // entries are sorted high to low, so ge is true on a prefix of the chain
  assign ge = occupied && (entry.prio >= cmd.item.prio);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      bpmq_pkg::OP_INSERT: begin
        if (!ge) begin
          entry_next = left_ge ? cmd.item : left_entry;
        end
      end
      bpmq_pkg::OP_REMOVE: entry_next = right_entry;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
